@@ hdl/prp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_pkg
// shared types, constants and the sine table generator for the rotary
// position rotate core
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int unsigned MAX_PAIRS_DEF        = 64;
    localparam int unsigned PHASE_INDEX_BITS_DEF = 12;

    localparam int unsigned ROPE_HALF_W   = 7;
    localparam int unsigned PAIR_W        = 6;
    localparam int unsigned POS_W         = 16;
    localparam int unsigned VAL_W         = 16;
    localparam int unsigned FREQ_W        = 32;
    localparam int unsigned MAG_W         = 16;
    localparam int unsigned IN_DATA_W     = 88;
    localparam int unsigned OUT_DATA_W    = 32;

    localparam logic [ROPE_HALF_W-1:0] ROPE_HALF_RESET = 7'd64;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_PASS,
        KIND_ROTATE
    } prp_kind_t;

    typedef struct packed {
        logic [MAG_W-1:0] sin_mag;
        logic [MAG_W-1:0] cos_mag;
        logic             sin_neg;
        logic             cos_neg;
    } prp_trig_t;

    typedef struct packed {
        logic      prod_en;
        logic      out_en;
        prp_kind_t kind;
    } prp_rot_ctrl_t;

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] prp_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // restoring quotient of two unsigned words, for building constant tables
    function automatic logic [63:0] prp_udiv64(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] part;
        quo  = 64'd0;
        part = 65'd0;
        for (int i = 63; i >= 0; i--)
        begin
            part = {part[63:0], num[i]};
            if (part >= {1'b0, den})
            begin
                part   = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(32767 * sin(pi/2 * k / quarter)), evaluated at elaboration only
    function automatic logic [15:0] prp_quarter_entry(input int unsigned k,
                                                      input int unsigned bits);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] div;
        frac = 64'(k) << (64 - bits);
        x    = prp_mul_q62(HALF_PI_Q62, frac);
        x2   = prp_mul_q62(x, x);
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 13; n++)
        begin
            div  = 64'((2 * n) * (2 * n + 1));
            term = prp_udiv64(prp_mul_q62(term, x2), div);
            if ((n & 1) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        if (s > ONE_Q62)
            s = ONE_Q62;
        v = (s >> 20) * 64'd32767;
        v = (v + (64'd1 << 41)) >> 42;
        return (v > 64'd32767) ? 16'd32767 : v[15:0];
    endfunction

endpackage

@@ hdl/partial_rotary_position_rotate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_rotary_position_rotate_core
// partial rotary position rotation of one element pair per word
// ----------------------------------------------------------------------------
// Takes one word per cycle when the output is not stalled and gives one
// result word per input word, in order. The five register stages are the
// inverse frequency table read, the 16x32 phase multiply, the sine/cosine ROM
// read, the four element products and the round/saturate stage; each stage
// holds while the one after it is full and stalled, so bubbles are squeezed
// out and input keeps flowing while a result waits. A load (tuser 0) with a
// pair index below MAX_PAIRS writes the table at acceptance and returns a zero
// word; a rotate reading an entry never loaded since reset returns undefined
// data. rope_half is written through cfg_we/cfg_wdata; the user must write it
// only while the core is idle, the core itself does not enforce this.
module partial_rotary_position_rotate_core #(
    parameter int unsigned MAX_PAIRS        = prp_pkg::MAX_PAIRS_DEF,
    parameter int unsigned PHASE_INDEX_BITS = prp_pkg::PHASE_INDEX_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [prp_pkg::ROPE_HALF_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pair_index, position, value_first, value_second, inv_freq_word, zero pad
    input  logic [prp_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rotated_first, rotated_second
    output logic [prp_pkg::OUT_DATA_W-1:0]     m_tdata,
    // saturated
    output logic                               m_tuser
);
    import prp_pkg::*;

    localparam int unsigned ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    logic [PAIR_W-1:0]       in_pair;
    logic [POS_W-1:0]        in_pos;
    logic signed [VAL_W-1:0] in_v0;
    logic signed [VAL_W-1:0] in_v1;
    logic [FREQ_W-1:0]       in_word;
    logic                    in_range;
    logic                    accept;
    prp_kind_t               in_kind;

    logic [ROPE_HALF_W-1:0] rope_half_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    prp_kind_t               kind1_reg;
    logic                    range1_reg;
    logic [POS_W-1:0]        pos1_reg;
    logic signed [VAL_W-1:0] v0_1_reg;
    logic signed [VAL_W-1:0] v1_1_reg;

    prp_kind_t                   kind2_reg;
    logic [PHASE_INDEX_BITS-1:0] idx2_reg;
    logic signed [VAL_W-1:0]     v0_2_reg;
    logic signed [VAL_W-1:0]     v1_2_reg;

    prp_kind_t               kind3_reg;
    logic signed [VAL_W-1:0] v0_3_reg;
    logic signed [VAL_W-1:0] v1_3_reg;

    logic [FREQ_W-1:0]       table_q;
    logic [FREQ_W-1:0]       entry;
    logic [POS_W+FREQ_W-1:0] phase_prod;
    prp_trig_t               trig;
    prp_rot_ctrl_t           rot_ctrl;

    logic signed [VAL_W-1:0] rot_first;
    logic signed [VAL_W-1:0] rot_second;

    always_comb
    begin
        in_pair  = s_tdata[5:0];
        in_pos   = s_tdata[21:6];
        in_v0    = s_tdata[37:22];
        in_v1    = s_tdata[53:38];
        in_word  = s_tdata[85:54];
        in_range = (32'(in_pair) < MAX_PAIRS);
        accept   = s_tvalid && s_tready;
        if (s_tuser == CMD_LOAD)
            in_kind = KIND_LOAD;
        else if ({1'b0, in_pair} >= rope_half_reg)
            in_kind = KIND_PASS;
        else
            in_kind = KIND_ROTATE;
    end

    // stall chain, each stage moves when empty or when the next one moves
    always_comb
    begin
        en5 = !v5_reg || m_tready;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
    end

    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rope_half_reg <= ROPE_HALF_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rope_half_reg <= cfg_wdata;
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    prp_freq_table #(
        .MAX_PAIRS (MAX_PAIRS),
        .ADDR_W    (ADDR_W)
    ) u_freq_table (
        .clk     (clk),
        .wr_en   (accept && (s_tuser == CMD_LOAD) && in_range),
        .wr_addr (ADDR_W'(in_pair)),
        .wr_data (in_word),
        .rd_en   (en1),
        .rd_addr (ADDR_W'(in_pair)),
        .rd_data (table_q)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            kind1_reg  <= in_kind;
            range1_reg <= in_range;
            pos1_reg   <= in_pos;
            v0_1_reg   <= in_v0;
            v1_1_reg   <= in_v1;
        end
    end

    // phase in turns, top fraction bits address the sine table
    always_comb
    begin
        entry      = range1_reg ? table_q : '0;
        phase_prod = (POS_W+FREQ_W)'(pos1_reg) * (POS_W+FREQ_W)'(entry);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            kind2_reg <= kind1_reg;
            idx2_reg  <= phase_prod[FREQ_W-1 -: PHASE_INDEX_BITS];
            v0_2_reg  <= v0_1_reg;
            v1_2_reg  <= v1_1_reg;
        end
    end

    prp_sine_rom #(
        .PHASE_INDEX_BITS (PHASE_INDEX_BITS)
    ) u_sine_rom (
        .clk       (clk),
        .en        (en3),
        .phase_idx (idx2_reg),
        .trig      (trig)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            kind3_reg <= kind2_reg;
            v0_3_reg  <= v0_2_reg;
            v1_3_reg  <= v1_2_reg;
        end
    end

    always_comb
    begin
        rot_ctrl.prod_en = en4;
        rot_ctrl.out_en  = en5;
        rot_ctrl.kind    = kind3_reg;
    end

    prp_rotate u_rotate (
        .clk            (clk),
        .ctrl           (rot_ctrl),
        .trig           (trig),
        .value_first    (v0_3_reg),
        .value_second   (v1_3_reg),
        .rotated_first  (rot_first),
        .rotated_second (rot_second),
        .saturated      (m_tuser)
    );

    assign m_tvalid = v5_reg;
    assign m_tdata  = {rot_second, rot_first};

`ifndef SYNTHESIS
    // a full pipeline behind a stalled output takes no new word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full and stalled");

    // an accepted word lands in the first stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted word lost at first stage");

    // a held first stage keeps its payload
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(pos1_reg) && $stable(kind1_reg)))
        else $error("stalled stage changed");

    // a stalled result word stays on the output unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !m_tready) |=> (v5_reg && $stable(rot_first) && $stable(rot_second)))
        else $error("stalled result changed");
`endif

endmodule

@@ hdl/prp_freq_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_freq_table
// inverse frequency table, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module prp_freq_table #(
    parameter int unsigned MAX_PAIRS = prp_pkg::MAX_PAIRS_DEF,
    parameter int unsigned ADDR_W    = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [prp_pkg::FREQ_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [prp_pkg::FREQ_W-1:0] rd_data
);
    import prp_pkg::*;

    logic [FREQ_W-1:0] mem [MAX_PAIRS];
    logic [FREQ_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/prp_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_sine_rom
// quarter wave sine table with two registered read ports for sine and cosine
// ----------------------------------------------------------------------------
module prp_sine_rom #(
    parameter int unsigned PHASE_INDEX_BITS = prp_pkg::PHASE_INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [PHASE_INDEX_BITS-1:0] phase_idx,
    output prp_pkg::prp_trig_t          trig
);
    import prp_pkg::*;

    localparam int unsigned QW      = PHASE_INDEX_BITS - 2;
    localparam int unsigned QUARTER = 1 << QW;

    logic [MAG_W-1:0] rom_q [QUARTER+1];

    logic [1:0]    quad_s;
    logic [1:0]    quad_c;
    logic [QW-1:0] rem;
    logic [QW:0]   sin_addr;
    logic [QW:0]   cos_addr;
    prp_trig_t     trig_reg;

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = prp_quarter_entry(k, PHASE_INDEX_BITS);
        assign rom_q[k] = ENTRY;
    end

    always_comb
    begin
        quad_s   = phase_idx[PHASE_INDEX_BITS-1 -: 2];
        quad_c   = quad_s + 2'd1;
        rem      = phase_idx[QW-1:0];
        sin_addr = quad_s[0] ? ((QW+1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
        cos_addr = quad_c[0] ? ((QW+1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg.sin_mag <= rom_q[sin_addr];
            trig_reg.cos_mag <= rom_q[cos_addr];
            trig_reg.sin_neg <= quad_s[1];
            trig_reg.cos_neg <= quad_c[1];
        end
    end

    assign trig = trig_reg;

endmodule

@@ hdl/prp_rotate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_rotate
// product stage and round/saturate stage of the pair rotation
// ----------------------------------------------------------------------------
module prp_rotate (
    input  logic                             clk,
    input  prp_pkg::prp_rot_ctrl_t           ctrl,
    input  prp_pkg::prp_trig_t               trig,
    input  logic signed [prp_pkg::VAL_W-1:0] value_first,
    input  logic signed [prp_pkg::VAL_W-1:0] value_second,
    output logic signed [prp_pkg::VAL_W-1:0] rotated_first,
    output logic signed [prp_pkg::VAL_W-1:0] rotated_second,
    output logic                             saturated
);
    import prp_pkg::*;

    function automatic logic [VAL_W:0] round_sat(input logic signed [33:0] sum);
        logic signed [33:0] r;
        logic signed [18:0] q;
        r = sum + 34'sd16384;
        q = r[33:15];
        if (q > 19'sd32767)
            return {1'b1, 16'h7FFF};
        else if (q < -19'sd32768)
            return {1'b1, 16'h8000};
        else
            return {1'b0, q[15:0]};
    endfunction

    logic signed [16:0] sin_val;
    logic signed [16:0] cos_val;

    logic signed [32:0] p_c0_reg;
    logic signed [32:0] p_s1_reg;
    logic signed [32:0] p_s0_reg;
    logic signed [32:0] p_c1_reg;
    logic signed [VAL_W-1:0] v0_reg;
    logic signed [VAL_W-1:0] v1_reg;
    prp_kind_t               kind_reg;

    logic signed [33:0] sum_a;
    logic signed [33:0] sum_b;
    logic [VAL_W:0]     res_a;
    logic [VAL_W:0]     res_b;

    logic signed [VAL_W-1:0] first_reg;
    logic signed [VAL_W-1:0] second_reg;
    logic                    sat_reg;
    logic signed [VAL_W-1:0] first_next;
    logic signed [VAL_W-1:0] second_next;
    logic                    sat_next;

    always_comb
    begin
        sin_val = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
        cos_val = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            p_c0_reg <= 33'(value_first)  * 33'(cos_val);
            p_s1_reg <= 33'(value_second) * 33'(sin_val);
            p_s0_reg <= 33'(value_first)  * 33'(sin_val);
            p_c1_reg <= 33'(value_second) * 33'(cos_val);
            v0_reg   <= value_first;
            v1_reg   <= value_second;
            kind_reg <= ctrl.kind;
        end
    end

    always_comb
    begin
        sum_a = 34'(p_c0_reg) - 34'(p_s1_reg);
        sum_b = 34'(p_s0_reg) + 34'(p_c1_reg);
        res_a = round_sat(sum_a);
        res_b = round_sat(sum_b);
        case (kind_reg)
            KIND_ROTATE:
            begin
                first_next  = res_a[VAL_W-1:0];
                second_next = res_b[VAL_W-1:0];
                sat_next    = res_a[VAL_W] | res_b[VAL_W];
            end
            KIND_PASS:
            begin
                first_next  = v0_reg;
                second_next = v1_reg;
                sat_next    = 1'b0;
            end
            default:
            begin
                first_next  = '0;
                second_next = '0;
                sat_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign rotated_first  = first_reg;
    assign rotated_second = second_reg;
    assign saturated      = sat_reg;

endmodule
